>>> rtl/page_framebuffer_pixel_blit_unit_defines.svh
// Assertion macros shared by the frame buffer blit unit.
// No dependencies; included by the modules that carry assertions.
`ifndef PAGE_FRAMEBUFFER_PIXEL_BLIT_UNIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_PIXEL_BLIT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PFB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfb assertion failed");

// Next-cycle implication, disabled during reset.
`define PFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfb assertion failed");

`endif

>>> rtl/pfb_pkg.sv
// Package for the frame buffer blit unit: screen geometry, request codes,
// and the command and status structs between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none
package pfb_pkg;
   localparam int SCREEN_COLS = 128;
   localparam int SCREEN_ROWS = 64;
   localparam int SCREEN_PAGES = (SCREEN_ROWS + 7) / 8;
   localparam int STORE_BYTES = SCREEN_COLS * SCREEN_PAGES;
   localparam int ADDR_W = $clog2(STORE_BYTES);
   // Wide enough for any column plus page offset and for STORE_BYTES itself.
   localparam int FULL_W = 14;

   typedef enum logic [1:0] {
      REQ_PIXEL = 2'd0,
      REQ_BLIT  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic load;       // latch the request fields
      logic clr_step;   // write zero at the clear pointer and advance it
      logic px_write;   // write the modified byte at the target address
      logic bit_next;   // move to the next bit of the bitmap byte
      logic blit_done;  // advance byte column and row counter
      logic rsp_load;   // load the result register
   } cmd_type;

   typedef struct packed {
      logic hit;        // target pixel is drawn and on screen
      logic bit_last;   // last bit of the bitmap byte
      logic clr_last;   // clear pointer at the last store byte
   } status_type;
endpackage
`default_nettype wire

>>> rtl/page_framebuffer_pixel_blit_unit.sv
// Requests are taken one at a time, in the idle state only. A read loads the store
// byte into the result register; a pixel write reads its target byte and writes it
// back when the pixel is on screen; a bitmap byte steps through its bits, with a
// read-modify-write for each drawn bit; a clear zeroes the whole store. A read waits
// while an earlier result is not yet taken. Reset: synchronous; a clearing pass over
// all STORE_BYTES bytes (1024 at 128x64) zeroes the store, while no request is taken.
`timescale 1ns / 1ps
`default_nettype none
module page_framebuffer_pixel_blit_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_type,
   input  wire logic [7:0] req_pos_x,
   input  wire logic [7:0] req_pos_y,
   input  wire logic       req_pixel_value,
   input  wire logic [7:0] req_bitmap_byte,
   input  wire logic [7:0] req_bitmap_width,
   input  wire logic       req_bitmap_first,
   input  wire logic       req_bitmap_invert,
   input  wire logic [9:0] req_read_index,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [7:0] rsp_read_data,
   output logic      [9:0] rsp_read_addr
);
   import pfb_pkg::*;

   cmd_type    cmd;
   status_type status;

   pfb_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pfb_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_type          (req_type),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pixel_value   (req_pixel_value),
      .req_bitmap_byte   (req_bitmap_byte),
      .req_bitmap_width  (req_bitmap_width),
      .req_bitmap_first  (req_bitmap_first),
      .req_bitmap_invert (req_bitmap_invert),
      .req_read_index    (req_read_index),
      .rsp_read_data     (rsp_read_data),
      .rsp_read_addr     (rsp_read_addr)
   );
endmodule
`default_nettype wire

>>> rtl/pfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/pfb_datapath.sv
// Datapath of the frame buffer blit unit: request registers, bitmap
// counters, pixel address logic, frame store RAM and result register.
// Depends on pfb_pkg and pfb_ram.
`timescale 1ns / 1ps
`default_nettype none
module pfb_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire pfb_pkg::cmd_type    cmd,
   output pfb_pkg::status_type      status,
   input  wire logic [1:0]          req_type,
   input  wire logic [7:0]          req_pos_x,
   input  wire logic [7:0]          req_pos_y,
   input  wire logic                req_pixel_value,
   input  wire logic [7:0]          req_bitmap_byte,
   input  wire logic [7:0]          req_bitmap_width,
   input  wire logic                req_bitmap_first,
   input  wire logic                req_bitmap_invert,
   input  wire logic [9:0]          req_read_index,
   output logic      [7:0]          rsp_read_data,
   output logic      [9:0]          rsp_read_addr
);
   import pfb_pkg::*;

   req_kind_type      kind_ff;
   logic [7:0]        x_ff, y_ff, src_ff, width_ff;
   logic              val_ff;
   logic [9:0]        ridx_ff;
   logic [7:0]        origin_col_ff, origin_col_in;
   logic [7:0]        origin_row_ff, origin_row_in;
   logic [7:0]        row_counter_ff, row_counter_in;
   logic [4:0]        byte_column_ff, byte_column_in;
   logic [2:0]        bit_ff, bit_in;
   logic [ADDR_W-1:0] clear_ptr_ff, clear_ptr_in;
   logic [7:0]        rsp_data_ff;
   logic [9:0]        rsp_addr_ff;

   logic [7:0]        src_idx, tgt_x, tgt_y;
   logic              on_screen, draw;
   logic [FULL_W-1:0] full_addr, ridx_ext;
   logic [ADDR_W-1:0] tgt_addr, rd_addr, wr_addr;
   logic              ridx_ok;
   logic [7:0]        rd_data, mask, wr_data;
   logic              wr_en, set_bit;
   logic [8:0]        width_sum;
   logic [5:0]        row_bytes, next_col;

   // Source pixel index within the bitmap row, and its screen position.
   assign src_idx = {byte_column_ff, bit_ff};
   assign tgt_x = (kind_ff == REQ_BLIT) ? 8'(origin_col_ff + src_idx) : x_ff;
   assign tgt_y = (kind_ff == REQ_BLIT) ? 8'(origin_row_ff + row_counter_ff) : y_ff;
   assign on_screen = ({1'b0, tgt_x} < 9'(SCREEN_COLS)) && ({1'b0, tgt_y} < 9'(SCREEN_ROWS));
   // Bit 7 of the source byte is the leftmost pixel.
   assign draw = (kind_ff != REQ_BLIT) || ((src_idx < width_ff) && src_ff[~bit_ff]);
   assign full_addr = FULL_W'(tgt_x) + FULL_W'(tgt_y[7:3]) * FULL_W'(SCREEN_COLS);
   assign tgt_addr = full_addr[ADDR_W-1:0];

   assign ridx_ext = FULL_W'(ridx_ff);
   assign ridx_ok = ridx_ext < FULL_W'(STORE_BYTES);
   assign rd_addr = (kind_ff == REQ_READ) ? ridx_ext[ADDR_W-1:0] : tgt_addr;

   assign mask = 8'(1) << tgt_y[2:0];
   assign set_bit = (kind_ff == REQ_BLIT) || val_ff;
   assign wr_en = cmd.px_write || cmd.clr_step;
   assign wr_addr = cmd.clr_step ? clear_ptr_ff : tgt_addr;
   assign wr_data = cmd.clr_step ? 8'd0 : (set_bit ? (rd_data | mask) : (rd_data & ~mask));

   pfb_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.hit = on_screen && draw;
   assign status.bit_last = (bit_ff == 3'd7);
   assign status.clr_last = (clear_ptr_ff == ADDR_W'(STORE_BYTES - 1));

   assign width_sum = {1'b0, width_ff} + 9'd7;
   assign row_bytes = width_sum[8:3];
   assign next_col = {1'b0, byte_column_ff} + 6'd1;

   always_comb begin
      origin_col_in = origin_col_ff;
      origin_row_in = origin_row_ff;
      row_counter_in = row_counter_ff;
      byte_column_in = byte_column_ff;
      bit_in = bit_ff;
      clear_ptr_in = clear_ptr_ff;
      if (cmd.load) begin
         bit_in = 3'd0;
         if ((req_kind_type'(req_type) == REQ_BLIT) && req_bitmap_first) begin
            origin_col_in = req_pos_x;
            origin_row_in = req_pos_y;
            row_counter_in = 8'd0;
            byte_column_in = 5'd0;
         end
      end
      if (cmd.bit_next) begin
         bit_in = bit_ff + 3'd1;
      end
      if (cmd.blit_done) begin
         if (next_col >= row_bytes) begin
            byte_column_in = 5'd0;
            row_counter_in = row_counter_ff + 8'd1;
         end else begin
            byte_column_in = next_col[4:0];
         end
      end
      if (cmd.clr_step) begin
         clear_ptr_in = status.clr_last ? '0 : clear_ptr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff <= 8'd0;
         origin_row_ff <= 8'd0;
         row_counter_ff <= 8'd0;
         byte_column_ff <= 5'd0;
         bit_ff <= 3'd0;
         clear_ptr_ff <= '0;
      end else begin
         origin_col_ff <= origin_col_in;
         origin_row_ff <= origin_row_in;
         row_counter_ff <= row_counter_in;
         byte_column_ff <= byte_column_in;
         bit_ff <= bit_in;
         clear_ptr_ff <= clear_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind_type'(req_type);
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
         val_ff <= req_pixel_value;
         src_ff <= req_bitmap_invert ? ~req_bitmap_byte : req_bitmap_byte;
         width_ff <= req_bitmap_width;
         ridx_ff <= req_read_index;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= ridx_ok ? rd_data : 8'd0;
         rsp_addr_ff <= ridx_ff;
      end
   end

   assign rsp_read_data = rsp_data_ff;
   assign rsp_read_addr = rsp_addr_ff;
endmodule
`default_nettype wire

>>> rtl/pfb_controller.sv
// Controller of the frame buffer blit unit: sequences clear sweeps,
// read-modify-write of pixels and bitmap bits, reads and the result handshake.
// Depends on pfb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "page_framebuffer_pixel_blit_unit_defines.svh"
module pfb_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_type,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output pfb_pkg::cmd_type         cmd,
   input  wire pfb_pkg::status_type status
);
   import pfb_pkg::*;

   typedef enum logic [8:0] {
      S_INIT     = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_CLEAR    = 9'b000000100,
      S_PIX      = 9'b000001000,
      S_PIX_WR   = 9'b000010000,
      S_BLIT     = 9'b000100000,
      S_BLIT_WR  = 9'b001000000,
      S_READ     = 9'b010000000,
      S_READ_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_INIT, S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_kind_type'(req_type))
                  REQ_PIXEL: state_in = S_PIX;
                  REQ_BLIT:  state_in = S_BLIT;
                  REQ_CLEAR: state_in = S_CLEAR;
                  REQ_READ:  state_in = S_READ;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_PIX: begin
            state_in = status.hit ? S_PIX_WR : S_IDLE;
         end
         S_PIX_WR: begin
            cmd.px_write = 1'b1;
            state_in = S_IDLE;
         end
         S_BLIT: begin
            // Bits that draw nothing skip the write cycle.
            if (status.hit) begin
               state_in = S_BLIT_WR;
            end else begin
               cmd.bit_next = 1'b1;
               if (status.bit_last) begin
                  cmd.blit_done = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_BLIT_WR: begin
            cmd.px_write = 1'b1;
            cmd.bit_next = 1'b1;
            if (status.bit_last) begin
               cmd.blit_done = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_BLIT;
            end
         end
         S_READ: begin
            state_in = S_READ_OUT;
         end
         S_READ_OUT: begin
            // The RAM keeps reading the same address, so the data holds
            // until the result register is free.
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PFB_ASSERT_NOW(a_no_write_when_ready, clock, reset, req_ready, !cmd.px_write && !cmd.clr_step)
   `PFB_ASSERT_NOW(a_rsp_load_slot_free, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_ready)
   `PFB_ASSERT_NEXT(a_rsp_load_valid, clock, reset, cmd.rsp_load, rsp_valid_ff)
   `PFB_ASSERT_NOW(a_single_writer, clock, reset, cmd.px_write, !cmd.clr_step)
   `PFB_ASSERT_NEXT(a_clear_ends_idle, clock, reset, cmd.clr_step && status.clr_last, req_ready)
endmodule
`default_nettype wire
